@@ src/k2s_pkg.sv @@
// Shared word type, constants and saturating-add helper of the K2 pair scorer.
`timescale 1ns / 1ps
package k2s_pkg;

  localparam int CellBits  = 17;
  localparam int Cells     = 9;
  localparam logic [CellBits-1:0] CellMax = 17'h1FFFF;
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  localparam logic [39:0] Mask40 = 40'hFF_FFFF_FFFF;

  // Register indexes on the configuration port
  localparam logic RegPadMask0 = 1'b0;
  localparam logic RegPadMask1 = 1'b1;

  // One classified word on its way to the back end
  typedef struct packed {
    logic [Cells-1:0][5:0] counts;
    logic                  cls;
    logic                  eop;
    logic [23:0]           pidx;
    logic                  new_search;
  } word_t;

  // Saturating add of a word count to a cell counter
  function automatic logic [CellBits-1:0] sat_add(input logic [CellBits-1:0] acc,
                                                  input logic [5:0] inc);
    logic [CellBits:0] s;
    s = {1'b0, acc} + {{(CellBits-5){1'b0}}, inc};
    sat_add = s[CellBits] ? CellMax : s[CellBits-1:0];
  endfunction

endpackage

@@ src/k2s_front.sv @@
// Front end: masks genotype planes and popcounts the nine cells of one word.
`timescale 1ns / 1ps
module k2s_front import k2s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pi0,
  input  logic [31:0] pi1,
  input  logic [31:0] pj0,
  input  logic [31:0] pj1,
  input  logic        cls,
  input  logic        fin,
  input  logic        eop,
  input  logic [23:0] pidx,
  input  logic        new_search,
  input  logic [31:0] pad0,
  input  logic [31:0] pad1,
  output logic        out_valid,
  input  logic        out_ready,
  output word_t       out_word
);

  logic [2:0][31:0] gi, gj;
  logic [31:0] pm;
  word_t w_next;

  always_comb begin
    pm = cls ? pad1 : pad0;
    gi[0] = pi0;
    gi[1] = pi1;
    gi[2] = ~(pi0 | pi1) & (fin ? pm : 32'hFFFF_FFFF);
    gj[0] = pj0;
    gj[1] = pj1;
    gj[2] = ~(pj0 | pj1) & (fin ? pm : 32'hFFFF_FFFF);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        w_next.counts[r*3+c] = 6'($countones(gi[r] & gj[c]));
      end
    end
    w_next.cls = cls;
    w_next.eop = eop;
    w_next.pidx = pidx;
    w_next.new_search = new_search;
  end

  assign in_ready = !out_valid || out_ready;

  // Output register holds one classified word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_word <= w_next;
    end
  end

endmodule

@@ src/k2s_fifo.sv @@
// Short queue of classified words between the front and the back end.
`timescale 1ns / 1ps
module k2s_fifo import k2s_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  word_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output word_t rd_data
);

  word_t       mem [4];
  logic [1:0]  wptr, rptr;
  logic [2:0]  count;
  logic        do_wr, do_rd;

  assign wr_ready = count != 3'd4;
  assign rd_valid = count != 3'd0;
  assign rd_data  = mem[rptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 2'd1;
      if (do_rd) rptr <= rptr + 2'd1;
      count <= count + {2'b0, do_wr} - {2'b0, do_rd};
    end
    if (do_wr) mem[wptr] <= wr_data;
  end

endmodule

@@ src/k2s_back.sv @@
// Back end: accumulates cell counters and scores a pair term by term.
`timescale 1ns / 1ps
module k2s_back import k2s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  word_t       in_word,
  output logic        empty,
  input  logic        pop,
  output logic [39:0] pair_score,
  output logic [23:0] scored_pair,
  output logic [39:0] best_score,
  output logic [23:0] best_pair
);

  typedef enum logic [3:0] {
    S_ACC, S_TERM, S_LOGSTART, S_LOG, S_LN1, S_LN2, S_G1, S_G2, S_ADD, S_FINAL, S_OUT
  } state_t;

  state_t state;
  logic [CellBits-1:0] cnt0 [Cells];
  logic [CellBits-1:0] cnt1 [Cells];
  logic [39:0] lowest_score;
  logic [23:0] lowest_pair;
  logic [23:0] cur_pidx;
  logic [3:0]  cell_idx;
  logic [1:0]  term;
  logic [17:0] n;
  logic [4:0]  top;
  logic [4:0]  top_next;
  logic [32:0] m;
  logic [31:0] frac;
  logic [5:0]  bit_cnt;
  logic [63:0] ln_val;
  logic [63:0] p_hi, p_lo;
  logic [100:0] g_prod;
  logic signed [71:0] sum;
  logic [65:0] msq;
  logic [71:0] mag, rnd;
  logic [17:0] n_sel;
  logic [63:0] lnsum;
  logic signed [71:0] g_val;
  logic [39:0] score;

  // Operand of the current term: a+b+1, a, or b
  always_comb begin
    case (term)
      2'd0: n_sel = {1'b0, cnt0[cell_idx]} + {1'b0, cnt1[cell_idx]} + 18'd1;
      2'd1: n_sel = {1'b0, cnt0[cell_idx]};
      default: n_sel = {1'b0, cnt1[cell_idx]};
    endcase
    // Index of the top set bit of the operand
    top_next = 5'd0;
    for (int k = 0; k < 18; k++) if (n[k]) top_next = 5'(k);
    msq = 66'(m) * 66'(m);
    lnsum = p_hi + {32'd0, p_lo[63:32]};
    g_val = $signed({8'd0, g_prod[64:1]}) - $signed({22'd0, n - 18'd1, 32'd0});
    mag = sum[71] ? 72'(-sum) : 72'(sum);
    rnd = (mag + 72'd32768) >> 16;
    score = (rnd == 72'd0 || rnd > {32'd0, Mask40}) ? Mask40 : rnd[39:0];
  end

  assign in_ready = state == S_ACC;
  assign empty = state != S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      for (int k = 0; k < Cells; k++) begin
        cnt0[k] <= '0;
        cnt1[k] <= '0;
      end
      lowest_score <= Mask40;
      lowest_pair <= '0;
    end else begin
      case (state)
        // Add word counts into the item's class bank
        S_ACC: begin
          if (in_valid) begin
            for (int k = 0; k < Cells; k++) begin
              if (in_word.cls) cnt1[k] <= sat_add(cnt1[k], in_word.counts[k]);
              else cnt0[k] <= sat_add(cnt0[k], in_word.counts[k]);
            end
            if (in_word.new_search) begin
              lowest_score <= Mask40;
              lowest_pair <= '0;
            end
            cur_pidx <= in_word.pidx;
            if (in_word.eop) begin
              state <= S_TERM;
              cell_idx <= '0;
              term <= '0;
              sum <= '0;
            end
          end
        end
        S_TERM: begin
          n <= n_sel;
          state <= (n_sel == 18'd0) ? S_ADD : S_LOGSTART;
          g_prod <= '0;
        end
        // Normalize: find the top bit of the operand
        S_LOGSTART: begin
          top <= top_next;
          state <= S_LOG;
          bit_cnt <= 6'd32;
          frac <= '0;
        end
        // Place the mantissa at bit 31, then one fraction bit of log2 per cycle by squaring
        S_LOG: begin
          if (bit_cnt == 6'd32) begin
            m <= 33'({15'd0, n} << (5'd31 - top));
            bit_cnt <= 6'd31;
          end else begin
            if (msq[65:31] >= 35'h1_0000_0000) begin
              m <= msq[64:32];
              frac <= {frac[30:0], 1'b1};
            end else begin
              m <= msq[63:31];
              frac <= {frac[30:0], 1'b0};
            end
            if (bit_cnt == 6'd0) state <= S_LN1;
            else bit_cnt <= bit_cnt - 6'd1;
          end
        end
        S_LN1: begin
          p_hi <= {59'd0, top} * {32'd0, Ln2Q32};
          p_lo <= {32'd0, frac} * {32'd0, Ln2Q32};
          state <= S_LN2;
        end
        S_LN2: begin
          ln_val <= lnsum;
          state <= S_G1;
        end
        // ln of an 18-bit operand stays below 2^36 in Q.32
        S_G1: begin
          g_prod <= 101'({n, 1'b1}) * 101'(ln_val[35:0]);
          state <= S_G2;
        end
        S_G2: state <= S_ADD;
        // Accumulate signed term
        S_ADD: begin
          if (n != 18'd0) begin
            if (term == 2'd0) sum <= sum + g_val;
            else sum <= sum - g_val;
          end
          if (term == 2'd2) begin
            term <= 2'd0;
            if (cell_idx == 4'(Cells - 1)) state <= S_FINAL;
            else begin
              cell_idx <= cell_idx + 4'd1;
              state <= S_TERM;
            end
          end else begin
            term <= term + 2'd1;
            state <= S_TERM;
          end
        end
        S_FINAL: begin
          pair_score <= score;
          scored_pair <= cur_pidx;
          if (score < lowest_score) begin
            lowest_score <= score;
            lowest_pair <= cur_pidx;
            best_score <= score;
            best_pair <= cur_pidx;
          end else begin
            best_score <= lowest_score;
            best_pair <= lowest_pair;
          end
          for (int k = 0; k < Cells; k++) begin
            cnt0[k] <= '0;
            cnt1[k] <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: if (pop) state <= S_ACC;
        default: state <= S_ACC;
      endcase
    end
  end

endmodule

@@ src/snp_pair_k2_scorer_core.sv @@
// Top level of the SNP pair K2 scorer: front end, word queue, back end.
// A word is counted after the front-end register and the word queue; a pair
// score follows its end-of-pair word, paced by the serial log2 unit (one
// fraction bit per cycle, 27 terms). Words stream at one per cycle unless the
// back end is busy. Reset clears counters, queue, best score (all ones).
`timescale 1ns / 1ps
module snp_pair_k2_scorer_core import k2s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] first_snp_plane0,
  input  logic [31:0] first_snp_plane1,
  input  logic [31:0] second_snp_plane0,
  input  logic [31:0] second_snp_plane1,
  input  logic        phenotype_class,
  input  logic        final_word_of_class,
  input  logic        end_of_pair,
  input  logic [23:0] pair_index,
  input  logic        new_search,
  output logic        empty,
  input  logic        pop,
  output logic [39:0] pair_score,
  output logic [23:0] scored_pair,
  output logic [39:0] best_score,
  output logic [23:0] best_pair
);

  logic [31:0] pad0, pad1;
  logic        f_valid, f_ready, q_valid, q_ready, in_ready;
  word_t       f_word, q_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pad0 <= 32'hFFFF_FFFF;
      pad1 <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      if (cfg_index == RegPadMask0) pad0 <= cfg_data;
      if (cfg_index == RegPadMask1) pad1 <= cfg_data;
    end
  end

  assign full = !in_ready;

  k2s_front u_front (
    .clk, .rst, .in_valid(push), .in_ready,
    .pi0(first_snp_plane0), .pi1(first_snp_plane1),
    .pj0(second_snp_plane0), .pj1(second_snp_plane1),
    .cls(phenotype_class), .fin(final_word_of_class), .eop(end_of_pair),
    .pidx(pair_index), .new_search, .pad0, .pad1,
    .out_valid(f_valid), .out_ready(f_ready), .out_word(f_word)
  );

  k2s_fifo u_fifo (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_word),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_word)
  );

  k2s_back u_back (
    .clk, .rst, .in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
    .empty, .pop, .pair_score, .scored_pair, .best_score, .best_pair
  );

endmodule

@@ test/tb_top.sv @@
// Testbench for the SNP pair K2 scorer: directed and random pairs, checked by a local predictor.
`timescale 1ns / 1ps
module tb_top;
  import k2s_pkg::*;

  typedef struct {
    logic [31:0] p0i, p1i, p0j, p1j;
    logic        cls, fin, eop;
    logic [23:0] pidx;
    logic        ns;
  } snp_word_t;

  typedef struct {
    logic [39:0] score;
    logic [23:0] pair;
    logic [39:0] best;
    logic [23:0] best_idx;
  } pair_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = RegPadMask0;
  logic [31:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] first_snp_plane0 = '0, first_snp_plane1 = '0;
  logic [31:0] second_snp_plane0 = '0, second_snp_plane1 = '0;
  logic        phenotype_class = 1'b0, final_word_of_class = 1'b0;
  logic        end_of_pair = 1'b0, new_search = 1'b0;
  logic [23:0] pair_index = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [39:0] pair_score, best_score;
  logic [23:0] scored_pair, best_pair;

  snp_pair_k2_scorer_core dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [16:0]  cell_cnt [18];
  logic [39:0]  run_best;
  logic [23:0]  run_best_pair;
  logic [31:0]  mask_c0 = '1, mask_c1 = '1;
  pair_result_t score_q [$];
  int           mismatches = 0;
  int           burst_left = 0;
  int           hold_cycles = 0;
  int           rx_mode = 0;
  longint       cycle_cnt = 0;

  // log2 in Q.32 by repeated squaring
  function automatic longint unsigned log2_q32(logic [31:0] n);
    int top;
    longint unsigned m, res;
    top = 31;
    while (top > 0 && !n[top]) top--;
    m = longint'(n << (31 - top)) & 64'hFFFF_FFFF;
    res = longint'(top) << 32;
    for (int b = 31; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        res = res | (64'd1 << b);
      end
    end
    return res;
  endfunction

  function automatic longint k2_term(logic [31:0] n);
    longint unsigned l, lnv, prod;
    if (n == 0) return 0;
    l = log2_q32(n);
    lnv = (l >> 32) * 64'd2977044472 + (((l & 64'hFFFF_FFFF) * 64'd2977044472) >> 32);
    prod = (longint'(2 * n + 1) * lnv) >> 1;
    return longint'(prod) - longint'(n - 1) * 64'sd4294967296;
  endfunction

  // Apply one accepted item to the predictor
  task automatic account_word(snp_word_t w);
    logic [31:0] gi [3], gj [3];
    logic [17:0] s;
    longint sum;
    longint unsigned mag, score;
    int base, a, b;
    pair_result_t r;
    if (w.ns) begin
      run_best = Mask40;
      run_best_pair = '0;
    end
    gi[0] = w.p0i; gi[1] = w.p1i; gi[2] = ~(w.p0i | w.p1i);
    gj[0] = w.p0j; gj[1] = w.p1j; gj[2] = ~(w.p0j | w.p1j);
    if (w.fin) begin
      gi[2] &= w.cls ? mask_c1 : mask_c0;
      gj[2] &= w.cls ? mask_c1 : mask_c0;
    end
    base = w.cls ? 9 : 0;
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++) begin
        s = {1'b0, cell_cnt[base + rr * 3 + cc]} + 18'($countones(gi[rr] & gj[cc]));
        cell_cnt[base + rr * 3 + cc] = (s > 18'd131071) ? 17'h1FFFF : s[16:0];
      end
    if (!w.eop) return;
    sum = 0;
    for (int c = 0; c < 9; c++) begin
      a = cell_cnt[c];
      b = cell_cnt[9 + c];
      sum += k2_term(32'(a + b + 1)) - k2_term(32'(a)) - k2_term(32'(b));
    end
    mag = (sum < 0) ? longint'(-sum) : longint'(sum);
    score = (mag + 32768) >> 16;
    if (score == 0 || score > 64'hFF_FFFF_FFFF) score = 64'hFF_FFFF_FFFF;
    if (score[39:0] < run_best) begin
      run_best = score[39:0];
      run_best_pair = w.pidx;
    end
    foreach (cell_cnt[k]) cell_cnt[k] = '0;
    r.score = score[39:0];
    r.pair = w.pidx;
    r.best = run_best;
    r.best_idx = run_best_pair;
    score_q.push_back(r);
  endtask

  // Offer one item, bursty sender; returns after the accepting edge
  task automatic send_word(snp_word_t w);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    first_snp_plane0 = w.p0i; first_snp_plane1 = w.p1i;
    second_snp_plane0 = w.p0j; second_snp_plane1 = w.p1j;
    phenotype_class = w.cls; final_word_of_class = w.fin;
    end_of_pair = w.eop; pair_index = w.pidx; new_search = w.ns;
    push = 1'b1;
    #1;
    while (full) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    account_word(w);
  endtask

  task automatic idle_input();
    @(negedge clk);
    push = 1'b0;
  endtask

  // Wait until every pending score is back, then let the pipe settle
  task automatic drain();
    idle_input();
    while (score_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == RegPadMask0) mask_c0 = val; else mask_c1 = val;
  endtask

  function automatic logic [31:0] rand_plane();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic snp_word_t rand_word(logic eop);
    snp_word_t w;
    w.p0i = rand_plane(); w.p1i = rand_plane();
    w.p0j = rand_plane(); w.p1j = rand_plane();
    w.cls = 1'($urandom_range(0, 1));
    w.fin = ($urandom_range(0, 3) == 0);
    w.eop = eop;
    w.pidx = 24'($urandom);
    w.ns = ($urandom_range(0, 15) == 0);
    return w;
  endfunction

  task automatic send_pair(int len);
    for (int k = 0; k < len; k++) send_word(rand_word(k == len - 1));
  endtask

  // Edge values, both-planes-set, every flag, single-word pair
  task automatic test_directed();
    snp_word_t w;
    w = '{'0, '0, '0, '0, 1'b0, 1'b0, 1'b1, 24'd0, 1'b1};
    send_word(w);                                    // single-word pair, all planes zero
    w = '{'1, '0, '0, '1, 1'b0, 1'b0, 1'b0, 24'hFFFFFF, 1'b0};
    send_word(w);
    w = '{'0, '1, '1, '0, 1'b1, 1'b0, 1'b1, 24'hFFFFFF, 1'b0};
    send_word(w);
    w = '{'1, '1, '1, '1, 1'b0, 1'b1, 1'b0, 24'h000001, 1'b0};  // both planes set
    send_word(w);
    w = '{32'hAAAA5555, 32'h0F0F0F0F, 32'h12345678, 32'h80000001, 1'b1, 1'b1, 1'b1,
          24'h800000, 1'b0};
    send_word(w);
    w = '{'0, '0, '0, '0, 1'b1, 1'b1, 1'b0, 24'h000002, 1'b0};
    send_word(w);
    w = '{'0, '0, '0, '0, 1'b0, 1'b0, 1'b1, 24'h000003, 1'b1};
    send_word(w);
    for (int k = 0; k < 6; k++) send_pair($urandom_range(1, 3));
  endtask

  task automatic test_pad_masks();
    write_reg(RegPadMask0, 32'h0000_0000);
    write_reg(RegPadMask1, 32'h0000_FFFF);
    send_pair(4);
    send_pair(2);
    write_reg(RegPadMask0, 32'hFFFF_FFFF);
    write_reg(RegPadMask1, 32'h0000_0000);
    send_pair(3);
  endtask

  // One long pair of identical words drives the genotype-2 cell to large counts
  task automatic test_long_pair();
    snp_word_t w;
    w = '{'0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 24'h00ABCD, 1'b0};
    for (int k = 0; k < 200; k++) begin
      w.eop = (k == 199);
      send_word(w);
    end
  endtask

  // Receiver held off while many short pairs pile up
  task automatic test_backpressure();
    drain();
    hold_cycles = 4000;
    for (int k = 0; k < 40; k++) send_pair(1);
  endtask

  task automatic test_random_pairs();
    int sent;
    sent = 0;
    while (sent < 630) begin
      int len;
      if ($urandom_range(0, 99) == 0) begin
        write_reg(RegPadMask0, $urandom);
        write_reg(RegPadMask1, $urandom);
      end
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
      send_pair(len);
      sent += len;
    end
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      pop = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: pop = 1'b1;
        1: pop = 1'($urandom_range(0, 1));
        default: pop = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (score_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected score for pair %h", scored_pair);
      end else begin
        pair_result_t e;
        e = score_q.pop_front();
        if (pair_score !== e.score || scored_pair !== e.pair ||
            best_score !== e.best || best_pair !== e.best_idx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %h got %h %h %h %h",
                     e.score, e.pair, e.best, e.best_idx,
                     pair_score, scored_pair, best_score, best_pair);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 5_000_000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    foreach (cell_cnt[k]) cell_cnt[k] = '0;
    run_best = Mask40;
    run_best_pair = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_pad_masks();
    test_long_pair();
    test_backpressure();
    drain();
    write_reg(RegPadMask0, 32'hFFFF_FFFF);
    write_reg(RegPadMask1, 32'hFFFF_FFFF);
    test_random_pairs();
    idle_input();
    while (score_q.size() != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
    if (mismatches == 0 && score_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
